// File: hdl/rgf_pkg.sv
package rgf_pkg;

    localparam int PIX_W     = 8;
    localparam int POS_W     = 6;
    localparam int RECT_W    = 9;
    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PATCH_WIDTH  = 1'b0;
    localparam t_cfg_idx CFG_PATCH_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] DIM_MIN         = 7'd2;
    localparam logic [DIM_W-1:0] PATCH_DIM_RESET = 7'd32;

    // Which result of a pixel the output sequencer is producing.
    typedef enum logic [1:0] {
        SLOT_MAIN,
        SLOT_EDGE,
        SLOT_CORNER
    } t_slot;

    // Position of an accepted pixel and the facts about it that the
    // gradient stage needs.
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             first_col;
        logic             second_col;
        logic             last_col;
        logic             last_row;
        logic             row_ge1;
        logic             row_is1;
        logic             sel;
    } t_pos;

endpackage

// File: hdl/rgf_ifs.sv
interface rgf_pix_if;
    logic                      valid;
    logic                      ready;
    logic                      start_req;
    logic [rgf_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output start_req, output pixel, input ready);
    modport sink (input valid, input start_req, input pixel, output ready);
endinterface

interface rgf_res_if;
    logic                       valid;
    logic                       ready;
    logic [rgf_pkg::POS_W-1:0]  row_index;
    logic [rgf_pkg::POS_W-1:0]  col_index;
    logic [rgf_pkg::RECT_W-1:0] pos_x;
    logic [rgf_pkg::RECT_W-1:0] neg_x;
    logic [rgf_pkg::RECT_W-1:0] pos_y;
    logic [rgf_pkg::RECT_W-1:0] neg_y;
    logic                       last;

    modport source (output valid, output row_index, output col_index, output pos_x,
                    output neg_x, output pos_y, output neg_y, output last, input ready);
    modport sink (input valid, input row_index, input col_index, input pos_x,
                  input neg_x, input pos_y, input neg_y, input last, output ready);
endinterface

interface rgf_cfg_if;
    logic                      valid;
    logic                      ready;
    rgf_pkg::t_cfg_idx         index;
    logic [rgf_pkg::DIM_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/rectified_gradient_field_core.sv
// Channel  | Direction | Carries
// ---------+-----------+--------------------------------------------------
// i_pix    | in        | start_req, pixel (one grey pixel, raster order)
// o_res    | out       | row_index, col_index, pos_x, neg_x, pos_y, neg_y, last
// i_cfg    | in        | index, data (patch_width = 0, patch_height = 1)
//
// One pixel request is taken per cycle while the pixel stage is free; each
// pixel of rows 1 and up gives one result. In the last row every pixel from
// column 1 on gives two results and the final pixel three. The single output
// register takes one result per cycle while o_res is not stalled.
// A result is formed from the pixel stage register into the output register.
// Reset is synchronous and active low; it clears counters, valid flags, the
// slot and the patch size registers, and needs no clearing pass since the line
// stores are only read where they have been written. Stalls on o_res hold the
// pixel stage and then the input; configuration writes are always taken.
module rectified_gradient_field_core #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rgf_pix_if.sink    i_pix,
    rgf_res_if.source  o_res,
    rgf_cfg_if.sink    i_cfg
);

    localparam int AW = $clog2(MAX_WIDTH);

    // The two line stores alternate: one receives the row being streamed in,
    // the other holds the row above. The one receiving the current row still
    // holds the row two above at the columns not yet overwritten, which is
    // exactly what the vertical difference of the row above needs.
    rgf_pkg::t_pos             w_pos;
    logic                      w_accept;
    logic                      w_ready;
    logic                      w_rd_en;
    logic [AW-1:0]             w_a_raddr;
    logic [AW-1:0]             w_b_raddr;
    logic                      w_a_we;
    logic                      w_b_we;
    logic [AW-1:0]             w_waddr;
    logic [rgf_pkg::PIX_W-1:0] w_qa;
    logic [rgf_pkg::PIX_W-1:0] w_qb;

    assign i_pix.ready = w_ready;
    assign w_accept    = i_pix.valid && w_ready;

    // Position tracking, configuration and line store addressing.
    rgf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_start_req (i_pix.start_req),
        .i_accept    (w_accept),
        .o_pos       (w_pos),
        .o_rd_en     (w_rd_en),
        .o_a_raddr   (w_a_raddr),
        .o_b_raddr   (w_b_raddr),
        .o_a_we      (w_a_we),
        .o_b_we      (w_b_we),
        .o_waddr     (w_waddr)
    );

    // Each store is read once per pixel and written at most once per pixel.
    // A same-entry read and write returns the old pixel, the row two above.
    rgf_ram #(
        .WIDTH (rgf_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_waddr),
        .i_wdata (i_pix.pixel),
        .i_re    (w_rd_en),
        .i_raddr (w_a_raddr),
        .o_rdata (w_qa)
    );

    rgf_ram #(
        .WIDTH (rgf_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_waddr),
        .i_wdata (i_pix.pixel),
        .i_re    (w_rd_en),
        .i_raddr (w_b_raddr),
        .o_rdata (w_qb)
    );

    // Pixel stage: gradient windows, result sequencing and the output register.
    rgf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_pos   (w_pos),
        .i_pixel (i_pix.pixel),
        .i_qa    (w_qa),
        .i_qb    (w_qb),
        .o_ready (w_ready),
        .o_res   (o_res)
    );

endmodule

// File: hdl/rgf_ram.sv
module rgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read and a write of the same entry in one cycle return the old data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/rgf_front.sv
module rgf_front #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgf_cfg_if.sink       i_cfg,
    input  logic          i_start_req,
    input  logic          i_accept,
    output rgf_pkg::t_pos o_pos,
    output logic          o_rd_en,
    output logic [AW-1:0] o_a_raddr,
    output logic [AW-1:0] o_b_raddr,
    output logic          o_a_we,
    output logic          o_b_we,
    output logic [AW-1:0] o_waddr
);

    localparam logic [rgf_pkg::DIM_W-1:0] MAX_W = rgf_pkg::DIM_W'(MAX_WIDTH);
    localparam logic [rgf_pkg::DIM_W-1:0] MAX_H = rgf_pkg::DIM_W'(MAX_HEIGHT);

    logic [rgf_pkg::DIM_W-1:0] r_patch_width;
    logic [rgf_pkg::DIM_W-1:0] r_patch_height;
    logic [AW-1:0]             r_col;
    logic [RW-1:0]             r_row;
    logic                      r_sel;

    logic [rgf_pkg::DIM_W-1:0] w;
    logic [rgf_pkg::DIM_W-1:0] h;
    logic                      restart;
    logic [AW-1:0]             c;
    logic [RW-1:0]             r;
    logic                      sel;
    logic                      last_col;
    logic                      last_row;
    logic [AW-1:0]             c_ahead;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_width  <= rgf_pkg::PATCH_DIM_RESET;
            r_patch_height <= rgf_pkg::PATCH_DIM_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rgf_pkg::CFG_PATCH_WIDTH:  r_patch_width  <= i_cfg.data;
                rgf_pkg::CFG_PATCH_HEIGHT: r_patch_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_patch_width < rgf_pkg::DIM_MIN) begin
            w = rgf_pkg::DIM_MIN;
        end else if (r_patch_width > MAX_W) begin
            w = MAX_W;
        end else begin
            w = r_patch_width;
        end
        if (r_patch_height < rgf_pkg::DIM_MIN) begin
            h = rgf_pkg::DIM_MIN;
        end else if (r_patch_height > MAX_H) begin
            h = MAX_H;
        end else begin
            h = r_patch_height;
        end
    end

    // A start request, or a position left outside a shrunken patch,
    // puts the pixel at the top left corner.
    assign restart  = i_start_req || (rgf_pkg::DIM_W'(r_col) >= w)
                      || (rgf_pkg::DIM_W'(r_row) >= h);
    assign c        = restart ? '0 : r_col;
    assign r        = restart ? '0 : r_row;
    assign sel      = restart ? 1'b0 : r_sel;
    assign last_col = (rgf_pkg::DIM_W'(c) == (w - 7'd1));
    assign last_row = (rgf_pkg::DIM_W'(r) == (h - 7'd1));
    assign c_ahead  = last_col ? c : AW'(c + 1'b1);

    // The store that the current row fills is A when sel is low; the other
    // holds the row above and is read one column ahead.
    assign o_rd_en   = i_accept;
    assign o_a_raddr = sel ? c_ahead : c;
    assign o_b_raddr = sel ? c : c_ahead;
    assign o_a_we    = i_accept && !sel;
    assign o_b_we    = i_accept && sel;
    assign o_waddr   = c;

    always_comb begin
        o_pos.row        = rgf_pkg::POS_W'(r);
        o_pos.col        = rgf_pkg::POS_W'(c);
        o_pos.first_col  = (c == '0);
        o_pos.second_col = (c == AW'(1));
        o_pos.last_col   = last_col;
        o_pos.last_row   = last_row;
        o_pos.row_ge1    = (r != '0);
        o_pos.row_is1    = (r == RW'(1));
        o_pos.sel        = sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_sel <= 1'b0;
        end else if (i_accept) begin
            if (last_col) begin
                r_col <= '0;
                r_sel <= !sel;
                r_row <= last_row ? '0 : RW'(r + 1'b1);
            end else begin
                r_col <= AW'(c + 1'b1);
                r_sel <= sel;
                r_row <= r;
            end
        end
    end

endmodule

// File: hdl/rgf_back.sv
module rgf_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  rgf_pkg::t_pos             i_pos,
    input  logic [rgf_pkg::PIX_W-1:0] i_pixel,
    input  logic [rgf_pkg::PIX_W-1:0] i_qa,
    input  logic [rgf_pkg::PIX_W-1:0] i_qb,
    output logic                      o_ready,
    rgf_res_if.source                 o_res
);

    typedef struct packed {
        logic [rgf_pkg::RECT_W-1:0] pos;
        logic [rgf_pkg::RECT_W-1:0] neg;
    } t_rect;

    // Twice the positive and twice the negative part of a - b.
    function automatic t_rect rectify(input logic [rgf_pkg::PIX_W-1:0] a,
                                      input logic [rgf_pkg::PIX_W-1:0] b);
        logic signed [rgf_pkg::PIX_W:0] d;
        logic signed [rgf_pkg::PIX_W:0] m;
        t_rect                          res;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        m = -d;
        res.pos = (d > 0) ? {d[rgf_pkg::PIX_W-1:0], 1'b0} : '0;
        res.neg = (d < 0) ? {m[rgf_pkg::PIX_W-1:0], 1'b0} : '0;
        return res;
    endfunction

    logic                      r_s1_valid;
    rgf_pkg::t_pos             r_s1_pos;
    logic [rgf_pkg::PIX_W-1:0] r_s1_pix;
    rgf_pkg::t_slot            r_slot;
    rgf_pkg::t_slot            n_slot;

    logic [rgf_pkg::PIX_W-1:0] r_win0;
    logic [rgf_pkg::PIX_W-1:0] r_win1;
    logic [rgf_pkg::PIX_W-1:0] r_d1;
    logic [rgf_pkg::PIX_W-1:0] r_d2;
    logic [rgf_pkg::PIX_W-1:0] r_first_cur;
    logic [rgf_pkg::PIX_W-1:0] r_first_prev;

    logic                       r_out_valid;
    logic [rgf_pkg::POS_W-1:0]  r_out_row;
    logic [rgf_pkg::POS_W-1:0]  r_out_col;
    t_rect                      r_out_x;
    t_rect                      r_out_y;
    logic                       r_out_last;

    logic [rgf_pkg::PIX_W-1:0] q_prev;
    logic [rgf_pkg::PIX_W-1:0] q_wr;
    logic [rgf_pkg::PIX_W-1:0] p_c;
    logic [rgf_pkg::PIX_W-1:0] p_cm1;
    logic                      has_edge;
    logic                      has_corner;
    logic                      out_free;
    logic                      emit;
    logic                      done;
    logic                      last_res;
    logic [rgf_pkg::PIX_W-1:0] xa;
    logic [rgf_pkg::PIX_W-1:0] xb;
    logic [rgf_pkg::PIX_W-1:0] ya;
    logic [rgf_pkg::PIX_W-1:0] yb;
    logic [rgf_pkg::POS_W-1:0] res_row;
    logic [rgf_pkg::POS_W-1:0] res_col;

    assign q_prev     = r_s1_pos.sel ? i_qa : i_qb;
    assign q_wr       = r_s1_pos.sel ? i_qb : i_qa;
    assign p_c        = r_s1_pos.first_col ? r_first_prev : r_win0;
    assign p_cm1      = r_s1_pos.second_col ? r_first_prev : r_win1;
    assign has_edge   = r_s1_pos.row_ge1 && r_s1_pos.last_row && !r_s1_pos.first_col;
    assign has_corner = r_s1_pos.row_ge1 && r_s1_pos.last_row && r_s1_pos.last_col;
    assign out_free   = !r_out_valid || o_res.ready;

    always_comb begin
        xa       = r_s1_pix;
        xb       = r_d1;
        ya       = r_s1_pix;
        yb       = p_c;
        res_row  = r_s1_pos.row;
        res_col  = r_s1_pos.col;
        last_res = 1'b1;
        n_slot   = r_slot;
        unique case (r_slot)
            rgf_pkg::SLOT_MAIN: begin
                // Element one row up, same column.
                if (r_s1_pos.first_col) begin
                    xa = q_prev;
                    xb = r_first_prev;
                end else if (r_s1_pos.last_col) begin
                    xa = p_c;
                    xb = p_cm1;
                end else begin
                    xa = q_prev;
                    xb = p_cm1;
                end
                yb       = r_s1_pos.row_is1 ? p_c : q_wr;
                res_row  = rgf_pkg::POS_W'(r_s1_pos.row - 1'b1);
                last_res = !has_edge;
            end
            rgf_pkg::SLOT_EDGE: begin
                // Bottom row element one column to the left.
                xb       = r_s1_pos.second_col ? r_d1 : r_d2;
                ya       = r_d1;
                yb       = p_cm1;
                res_col  = rgf_pkg::POS_W'(r_s1_pos.col - 1'b1);
                last_res = !has_corner;
            end
            rgf_pkg::SLOT_CORNER: begin
                last_res = 1'b1;
            end
            default: begin
                last_res = 1'b1;
            end
        endcase

        emit = r_s1_valid && r_s1_pos.row_ge1 && out_free;
        done = r_s1_valid && (!r_s1_pos.row_ge1 || (out_free && last_res));

        if (done) begin
            n_slot = rgf_pkg::SLOT_MAIN;
        end else if (emit) begin
            n_slot = (r_slot == rgf_pkg::SLOT_MAIN) ? rgf_pkg::SLOT_EDGE
                                                     : rgf_pkg::SLOT_CORNER;
        end
    end

    assign o_ready = !r_s1_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= rgf_pkg::SLOT_MAIN;
        end else begin
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (done) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_pos <= i_pos;
            r_s1_pix <= i_pixel;
            if (i_pos.first_col) begin
                r_first_prev <= r_first_cur;
                r_first_cur  <= i_pixel;
            end
        end
        // The column windows move on as each pixel leaves the stage.
        if (done) begin
            r_win1 <= r_win0;
            r_win0 <= q_prev;
            r_d2   <= r_d1;
            r_d1   <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_row  <= res_row;
            r_out_col  <= res_col;
            r_out_x    <= rectify(xa, xb);
            r_out_y    <= rectify(ya, yb);
            r_out_last <= last_res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.row_index = r_out_row;
    assign o_res.col_index = r_out_col;
    assign o_res.pos_x     = r_out_x.pos;
    assign o_res.neg_x     = r_out_x.neg;
    assign o_res.pos_y     = r_out_y.pos;
    assign o_res.neg_y     = r_out_y.neg;
    assign o_res.last      = r_out_last;

endmodule

// File: hdl/rgf_checker.sv
module rgf_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_res_valid,
    input logic                      i_res_ready,
    input logic [rgf_pkg::POS_W-1:0] i_row_index,
    input logic [rgf_pkg::POS_W-1:0] i_col_index,
    input logic                      i_last
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its position and end flag.
    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            $stable(i_row_index) && $stable(i_col_index) && $stable(i_last))
        else $error("result changed while stalled");

    // The remaining results of a pixel follow without a gap.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready && !i_last |=> i_res_valid)
        else $error("gap inside the results of one pixel");

    // Within one pixel the element moves one row down and one column left,
    // or one column right along the bottom row.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready && !i_last |=>
            ((i_row_index == rgf_pkg::POS_W'($past(i_row_index) + 1'b1)) &&
             (i_col_index == rgf_pkg::POS_W'($past(i_col_index) - 1'b1))) ||
            ((i_row_index == $past(i_row_index)) &&
             (i_col_index == rgf_pkg::POS_W'($past(i_col_index) + 1'b1))))
        else $error("results of one pixel out of order");

endmodule

bind rectified_gradient_field_core rgf_checker u_rgf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_row_index (o_res.row_index),
    .i_col_index (o_res.col_index),
    .i_last      (o_res.last)
);
